/* hw/rtl/modular_exponentiation_defines.svh */
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared property wrappers for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MODEXP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("modexp check failed");

// Next-cycle implication, disabled while reset is asserted
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("modexp check failed");

`endif

/* hw/rtl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths, register indexes and shared types of the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int MOD_W        = 31;  // modulus and result width
	localparam int EXP_W        = 32;  // exponent register width
	localparam int BASE_W       = 32;  // input base width
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int EXP_BITS_DEF = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;

	// Request to the multiply-reduce unit: a * b mod n, b <= n
	typedef struct packed {
		logic              start;
		logic [BASE_W-1:0] a;
		logic [MOD_W-1:0]  b;
	} mm_req_t;

	// Response from the multiply-reduce unit
	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] prod;
	} mm_rsp_t;

endpackage

/* hw/rtl/modexp_ifs.sv */
// ----------------------------------------------------------------------------
// modexp channel interfaces
// Valid/ready channels for the input base and the result.
// ----------------------------------------------------------------------------
interface modexp_base_if import modexp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink (input valid, input base_value, output ready);
endinterface

interface modexp_result_if import modexp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MOD_W-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

/* hw/rtl/modexp_mm.sv */
// ----------------------------------------------------------------------------
// modexp_mm
// Bit-serial interleaved multiply-reduce: a * b mod n, one bit of a per cycle,
// MSB first. Requires b <= n and n != 0; the partial residue stays below n.
// ----------------------------------------------------------------------------
module modexp_mm import modexp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mm_req_t          req,
	input  logic [MOD_W-1:0] modulus,
	output mm_rsp_t          rsp
);

	localparam int CNT_W = $clog2(BASE_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BASE_W-1:0] a_q;
	logic [MOD_W-1:0]  b_q;
	logic [MOD_W-1:0]  r_q;

	logic [MOD_W+1:0]  sum;    // 2r + b, below 3n
	logic [MOD_W+2:0]  diff1;  // sum - n
	logic [MOD_W+2:0]  diff2;  // sum - 2n
	logic [MOD_W-1:0]  r_next;

	// One step: double, add b on a set bit, pull back below n
	always_comb begin
		sum   = {1'b0, r_q, 1'b0} + (a_q[BASE_W-1] ? {2'b00, b_q} : '0);
		diff1 = {1'b0, sum} - {3'b000, modulus};
		diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
		priority if (!diff2[MOD_W+2]) begin
			r_next = diff2[MOD_W-1:0];
		end else if (!diff1[MOD_W+2]) begin
			r_next = diff1[MOD_W-1:0];
		end else begin
			r_next = sum[MOD_W-1:0];
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BASE_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operands and partial residue
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[BASE_W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = r_q;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// The block takes one base per transaction and returns one power_result. It
// first reduces the base modulo the modulus, then scans EXP_BITS exponent
// bits from the LSB: a set bit multiplies the accumulator by the running
// square, and every bit squares the square. All products go through one
// shared bit-serial multiply-reduce unit; a zero modulus gives 0 without
// any product. base_ch.ready is high only between items, while a finished
// result may still sit in the output register. A zero exponent gives 1,
// also for a modulus of 1. Write modulus and exponent only while the block
// is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; #(
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	modexp_base_if.sink           base_ch,
	modexp_result_if.source       result_ch
);

	localparam int IT_W = $clog2(EXP_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_BIT,
		S_MUL,
		S_SQR,
		S_DONE
	} state_t;

	state_t            state_q;
	mm_req_t           req_q;
	mm_rsp_t           rsp;
	logic [MOD_W-1:0]  modulus_q;
	logic [EXP_W-1:0]  exponent_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  sq_q;
	logic [EXP_W-1:0]  e_q;
	logic [IT_W-1:0]   it_q;
	logic              out_valid_q;
	logic [MOD_W-1:0]  result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_W'(1);
			exponent_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MODULUS:  modulus_q  <= cfg_wdata[MOD_W-1:0];
				CFG_EXPONENT: exponent_q <= cfg_wdata[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiply-reduce unit
	modexp_mm u_mm (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.modulus (modulus_q),
		.rsp     (rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			sq_q        <= '0;
			e_q         <= '0;
			it_q        <= '0;
			result_q    <= '0;
		end else begin
			// output register: load a finished result or drain on ready
			if (state_q == S_DONE && (!out_valid_q || result_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (base_ch.valid) begin
						if (modulus_q == '0) begin
							req_q.start <= 1'b0;
							acc_q       <= '0;
							state_q     <= S_DONE;
						end else begin
							// base mod n as base * 1
							req_q.start <= 1'b1;
							req_q.a     <= base_ch.base_value;
							req_q.b     <= MOD_W'(1);
							state_q     <= S_RED;
						end
					end else begin
						req_q.start <= 1'b0;
					end
				end
				S_RED: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						sq_q    <= rsp.prod;
						acc_q   <= MOD_W'(1);
						e_q     <= exponent_q;
						it_q    <= '0;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					priority if (it_q == IT_W'(EXP_BITS)) begin
						req_q.start <= 1'b0;
						state_q     <= S_DONE;
					end else if (e_q[0]) begin
						req_q.start <= 1'b1;
						req_q.a     <= BASE_W'(acc_q);
						req_q.b     <= sq_q;
						state_q     <= S_MUL;
					end else begin
						req_q.start <= 1'b1;
						req_q.a     <= BASE_W'(sq_q);
						req_q.b     <= sq_q;
						state_q     <= S_SQR;
					end
				end
				S_MUL: begin
					if (rsp.done) begin
						acc_q       <= rsp.prod;
						req_q.start <= 1'b1;
						req_q.a     <= BASE_W'(sq_q);
						req_q.b     <= sq_q;
						state_q     <= S_SQR;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				S_SQR: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						sq_q    <= rsp.prod;
						e_q     <= {1'b0, e_q[EXP_W-1:1]};
						it_q    <= it_q + 1'b1;
						state_q <= S_BIT;
					end
				end
				S_DONE: begin
					req_q.start <= 1'b0;
					if (!out_valid_q || result_ch.ready) begin
						result_q <= acc_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					req_q.start <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	assign base_ch.ready          = (state_q == S_IDLE);
	assign result_ch.valid        = out_valid_q;
	assign result_ch.power_result = result_q;

endmodule

/* hw/rtl/modexp_checker.sv */
// ----------------------------------------------------------------------------
// modexp_checker
// Port-level checks of the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modexp_checker import modexp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic                  base_valid,
	input logic                  base_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic [MOD_W-1:0]      power_result
);

	logic [MOD_W-1:0] mod_q;

	// Shadow of the modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_W'(1);
		end else if (cfg_we && cfg_idx == CFG_MODULUS) begin
			mod_q <= cfg_wdata[MOD_W-1:0];
		end
	end

	// One item at a time: input closes right after a transaction
	`MODEXP_ASSERT_NEXT(a_one_in_flight, clk, arst_n, base_valid && base_ready, !base_ready)

	// A stalled result stays and holds its value
	`MODEXP_ASSERT_NEXT(a_result_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(power_result))

	// A result is a proper residue once the modulus exceeds one
	`MODEXP_ASSERT_SAME(a_result_range, clk, arst_n, res_valid && mod_q > MOD_W'(1), power_result < mod_q)

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_idx      (cfg_idx),
	.cfg_wdata    (cfg_wdata),
	.base_valid   (base_ch.valid),
	.base_ready   (base_ch.ready),
	.res_valid    (result_ch.valid),
	.res_ready    (result_ch.ready),
	.power_result (result_ch.power_result)
);

/* tb/modular_exponentiation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation core.
// ----------------------------------------------------------------------------
// Bases are fed through the base channel from a queue of pending values.
// Each accepted base is predicted at once with square-and-multiply on the
// bench's own copy of the modulus and exponent, and the result channel is
// checked in order against those predictions. Registers change only once
// the core has drained. A directed part covers the extremes, a zero
// exponent, a zero modulus from masked write data and ignored register
// indexes. Random batches follow, each with its own register setting.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb import modexp_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int LONG_HOLD     = 3000;  // longer than the slowest item
	localparam int BATCHES       = 9;
	localparam int BATCH_ITEMS   = 30;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_MODULUS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic              base_valid   = 1'b0;
	logic [BASE_W-1:0] base_value   = '0;
	logic              result_ready = 1'b0;

	modexp_base_if   base_if ();
	modexp_result_if result_if ();

	assign base_if.valid      = base_valid;
	assign base_if.base_value = base_value;
	assign result_if.ready    = result_ready;

	modular_exponentiation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.base_ch   (base_if),
		.result_ch (result_if)
	);

	// Bench copy of the configuration registers
	logic [MOD_W-1:0] modulus_reg  = MOD_W'(1);
	logic [EXP_W-1:0] exponent_reg = '0;

	logic [BASE_W-1:0] pending_bases[$];
	logic [MOD_W-1:0]  power_q[$];

	bit offering    = 1'b0;
	bit tx_idle     = 1'b1;
	bit rx_idle     = 1'b1;
	int tx_wait     = 0;
	int rx_wait     = 0;
	int rx_hold     = 0;
	int hold_trigger = 0;
	int hold_seen   = 0;
	int error_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// base ^ exponent mod modulus, right-to-left square-and-multiply
	function automatic logic [MOD_W-1:0] modexp_predict(input logic [BASE_W-1:0] b,
			input logic [MOD_W-1:0] n, input logic [EXP_W-1:0] e);
		logic [63:0] sq;
		logic [63:0] acc;
		logic [63:0] n64;
		if (n == '0)
			return '0;
		n64 = {33'd0, n};
		sq  = {32'd0, b} % n64;
		acc = 64'd1;
		for (int i = 0; i < EXP_BITS_DEF && i < EXP_W; i++) begin
			if (e[i])
				acc = (acc * sq) % n64;
			sq = (sq * sq) % n64;
		end
		return acc[MOD_W-1:0];
	endfunction

	// Base channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid <= 1'b0;
			base_value <= '0;
		end else begin
			if (base_valid && base_if.ready) begin
				power_q.push_back(modexp_predict(base_value, modulus_reg, exponent_reg));
				offering = 1'b0;
				tx_wait  = tx_idle ? $urandom_range(0, 15) : 0;
			end
			if (!offering) begin
				if (tx_wait > 0) begin
					tx_wait--;
					base_valid <= 1'b0;
				end else if (pending_bases.size() != 0) begin
					base_value <= pending_bases.pop_front();
					base_valid <= 1'b1;
					offering = 1'b1;
				end else begin
					base_valid <= 1'b0;
				end
			end
		end
	end

	// Result channel monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_if.valid && result_ready) begin
				if (power_q.size() == 0) begin
					$display("%0t: unexpected power_result, expected none, actual %h",
						$time, result_if.power_result);
					error_count++;
				end else begin
					if (power_q[0] !== result_if.power_result) begin
						$display("%0t: power_result mismatch, expected %h, actual %h",
							$time, power_q[0], result_if.power_result);
						error_count++;
					end
					void'(power_q.pop_front());
				end
				rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
			end
			// long hold-off requested by the sequence
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				rx_hold   = LONG_HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				result_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Register write, only while the core is idle
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODULUS:  modulus_reg = data[MOD_W-1:0];
			CFG_EXPONENT: exponent_reg = data[EXP_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every queued base has been sent and every result checked
	task automatic drain_results();
		do
			@(posedge clk);
		while (pending_bases.size() != 0 || offering || power_q.size() != 0);
	endtask

	task automatic random_config();
		logic [CFG_DATA_W-1:0] m;
		logic [CFG_DATA_W-1:0] e;
		case ($urandom_range(0, 3))
			0: m = $urandom;
			1: m = {1'($urandom_range(0, 1)), 31'($urandom_range(2, 1000))};
			2: m = 32'h7FFF_FFFF - $urandom_range(0, 1000);
			default: m = $urandom_range(1, 3);
		endcase
		case ($urandom_range(0, 4))
			0: e = $urandom;
			1: e = $urandom_range(0, 255);
			2: e = 32'd65537;
			3: e = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 31));
			default: e = 32'd1 << $urandom_range(0, 31);
		endcase
		set_reg(CFG_MODULUS, m);
		set_reg(CFG_EXPONENT, e);
	endtask

	task automatic queue_random_bases(input int count);
		logic [BASE_W-1:0] b;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0: b = '0;
				1: b = {1'b0, modulus_reg} - 32'd1;
				2: b = {1'b0, modulus_reg};
				3: b = $urandom_range(0, 2);
				default: b = $urandom;
			endcase
			pending_bases.push_back(b);
		end
	endtask

	// Stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// registers at reset: zero exponent with modulus 1 gives 1
		pending_bases.push_back('0);
		pending_bases.push_back(32'hFFFF_FFFF);
		drain_results();

		// largest modulus and exponent, no idling on either side
		tx_idle <= 1'b0;
		rx_idle <= 1'b0;
		set_reg(CFG_MODULUS, 32'h7FFF_FFFF);
		set_reg(CFG_EXPONENT, 32'hFFFF_FFFF);
		pending_bases.push_back('0);
		pending_bases.push_back(32'd1);
		pending_bases.push_back(32'hFFFF_FFFF);
		pending_bases.push_back(32'h7FFF_FFFF);
		pending_bases.push_back(32'h7FFF_FFFE);
		pending_bases.push_back(32'h8000_0000);
		drain_results();

		// small textbook key pair, encrypt then decrypt
		tx_idle <= 1'b1;
		rx_idle <= 1'b1;
		set_reg(CFG_MODULUS, 32'd3233);
		set_reg(CFG_EXPONENT, 32'd17);
		pending_bases.push_back(32'd65);
		pending_bases.push_back('0);
		pending_bases.push_back(32'd3232);
		drain_results();
		set_reg(CFG_EXPONENT, 32'd2753);
		pending_bases.push_back(32'd2790);
		drain_results();

		// bit 31 of the write data is dropped: modulus becomes zero
		set_reg(CFG_MODULUS, 32'h8000_0000);
		pending_bases.push_back(32'd5);
		pending_bases.push_back(32'hFFFF_FFFF);
		drain_results();

		// writes to unused indexes change nothing
		set_reg(CFG_MODULUS, 32'd1);
		set_reg(CFG_EXPONENT, 32'd5);
		set_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
		set_reg(CFG_SPARE_3, 32'h5A5A_5A5A);
		pending_bases.push_back(32'd7);
		drain_results();

		// zero exponent with a large modulus, then exponent 1
		set_reg(CFG_MODULUS, 32'h7FFF_FFFF);
		set_reg(CFG_EXPONENT, '0);
		pending_bases.push_back(32'd123);
		drain_results();
		set_reg(CFG_EXPONENT, 32'd1);
		pending_bases.push_back(32'hFFFF_FFFF);
		drain_results();

		// only the top exponent bit set
		set_reg(CFG_MODULUS, 32'd2);
		set_reg(CFG_EXPONENT, 32'h8000_0000);
		pending_bases.push_back(32'd3);
		pending_bases.push_back(32'hFFFF_FFFE);
		drain_results();

		// result side stalls long enough to back up the input
		tx_idle <= 1'b0;
		set_reg(CFG_MODULUS, 32'd65521);
		set_reg(CFG_EXPONENT, 32'd65537);
		hold_trigger <= hold_trigger + 1;
		queue_random_bases(6);
		drain_results();

		// random batches, each with its own setting and idling mix
		for (int k = 0; k < BATCHES; k++) begin
			tx_idle <= ($urandom_range(0, 3) != 0);
			rx_idle <= ($urandom_range(0, 3) != 0);
			random_config();
			queue_random_bases(BATCH_ITEMS);
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("modular_exponentiation test passed");
		else
			$display("modular_exponentiation test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#70_000_000;
		$display("modular_exponentiation test failed");
		$finish;
	end

endmodule
